### rtl/radial_gradient_pixel_unit_macros.svh
// Assertion macros shared by the radial gradient pixel RTL.
`ifndef RADIAL_GRADIENT_PIXEL_UNIT_MACROS_SVH
`define RADIAL_GRADIENT_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RGP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RGP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rgp_pkg.sv
// Shared constants for the radial gradient pixel unit.
package rgp_pkg;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;
  localparam int MAXD_BITS      = 12;
  localparam int CHAN_BITS      = 8;
  localparam int COLOR_BITS     = 3 * CHAN_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DIST = 2'd2;

  localparam int CENTER_X_RESET = 400;
  localparam int CENTER_Y_RESET = 300;
  localparam int MAX_DIST_RESET = 500;

  localparam logic [CHAN_BITS-1:0] CHAN_FULL = 8'hFF;
  localparam logic [CHAN_BITS-1:0] CHAN_ZERO = 8'h00;

endpackage

### rtl/radial_gradient_pixel_unit.sv
// Radial gradient pixel unit: coordinate in, packed red/blue color out.
//
// Each accepted (in_pixel_x, in_pixel_y) gives one out_pixel_color. The distance from the
// configured center is the floor square root of dx*dx + dy*dy; red is
// distance*255/max_distance saturated at 255 (255 when max_distance is zero), blue is
// 255 - red, green is zero. One item is taken every cycle as long as the output side keeps
// up; from input accept to output valid an item passes the difference, square and sum
// stages, the square root (one result bit per stage, COORD_BITS + 1 stages), a scale
// stage and the divide (one quotient bit per stage, 8 stages). A two-entry output buffer
// lets the pipeline drain one item into it when out_ready drops. Write the cfg_ registers
// only while no item is in flight; a write to an index past max_distance is ignored.

`include "radial_gradient_pixel_unit_macros.svh"

module radial_gradient_pixel_unit #(
  parameter int COORD_BITS = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              in_pixel_x,
  input  logic [COORD_BITS-1:0]              in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rgp_pkg::COLOR_BITS-1:0]     out_pixel_color,
  input  logic                               cfg_wr_en,
  input  logic [rgp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rgp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int CB       = rgp_pkg::CHAN_BITS;
  localparam int SQ_BITS  = 2 * COORD_BITS;
  localparam int SUM_BITS = SQ_BITS + 1;
  localparam int RB       = COORD_BITS + 1;          // root bits
  localparam int RAD_BITS = 2 * RB;
  localparam int REM_BITS = RB + 3;
  localparam int NUM_BITS = RB + CB;
  localparam int DMIN     = rgp_pkg::MAXD_BITS + CB;
  localparam int DW       = (NUM_BITS > DMIN) ? NUM_BITS : DMIN;
  localparam int NST      = 4 + RB + CB;             // diff, square, sum, root, scale, divide
  localparam int LAST     = NST - 1;

  // configuration
  logic [COORD_BITS-1:0]         cfg_center_x_r;
  logic [COORD_BITS-1:0]         cfg_center_y_r;
  logic [rgp_pkg::MAXD_BITS-1:0] cfg_max_dist_r;

  // pipeline
  logic [NST-1:0]        vld_r;
  logic                  en;
  logic [COORD_BITS-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic [SQ_BITS-1:0]    sq_x_r, sq_y_r;

  logic [RAD_BITS-1:0] rad_r    [0:RB];
  logic [REM_BITS-1:0] rem_r    [0:RB];
  logic [RB-1:0]       root_r   [0:RB];
  logic [RAD_BITS-1:0] rad_nxt  [1:RB];
  logic [REM_BITS-1:0] rem_nxt  [1:RB];
  logic [RB-1:0]       root_nxt [1:RB];

  logic [NUM_BITS-1:0] num_nxt;
  logic [DW-1:0]       drem_r   [0:CB];
  logic [CB-1:0]       dq_r     [0:CB];
  logic                dsat_r   [0:CB];
  logic [DW-1:0]       drem_nxt [1:CB];
  logic [CB-1:0]       dq_nxt   [1:CB];
  logic                dsat_nxt [1:CB];

  logic [CB-1:0]                  red;
  logic [rgp_pkg::COLOR_BITS-1:0] color_nxt;

  // output buffer
  logic                           out_valid_r, skid_valid_r;
  logic [rgp_pkg::COLOR_BITS-1:0] out_color_r, skid_color_r;
  logic                           push, take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_center_x_r <= COORD_BITS'(rgp_pkg::CENTER_X_RESET);
      cfg_center_y_r <= COORD_BITS'(rgp_pkg::CENTER_Y_RESET);
      cfg_max_dist_r <= rgp_pkg::MAXD_BITS'(rgp_pkg::MAX_DIST_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgp_pkg::CFG_CENTER_X: cfg_center_x_r <= cfg_wdata[COORD_BITS-1:0];
        rgp_pkg::CFG_CENTER_Y: cfg_center_y_r <= cfg_wdata[COORD_BITS-1:0];
        rgp_pkg::CFG_MAX_DIST: cfg_max_dist_r <= cfg_wdata[rgp_pkg::MAXD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_valid_r;
  assign en       = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  assign dx_nxt = (in_pixel_x >= cfg_center_x_r) ? in_pixel_x - cfg_center_x_r
                                                  : cfg_center_x_r - in_pixel_x;
  assign dy_nxt = (in_pixel_y >= cfg_center_y_r) ? in_pixel_y - cfg_center_y_r
                                                  : cfg_center_y_r - in_pixel_y;

  // square root: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [REM_BITS-1:0] rp;
    logic [REM_BITS-1:0] trial;
    logic                ge;
    for (int k = 0; k < RB; k++) begin
      rp    = {rem_r[k][REM_BITS-3:0], rad_r[k][RAD_BITS-1 -: 2]};
      trial = REM_BITS'({root_r[k], 2'b01});
      ge    = (rp >= trial);
      rem_nxt[k+1]  = ge ? rp - trial : rp;
      root_nxt[k+1] = {root_r[k][RB-2:0], ge};
      rad_nxt[k+1]  = rad_r[k] << 2;
    end
  end

  assign num_nxt = NUM_BITS'({root_r[RB], CB'(0)}) - NUM_BITS'(root_r[RB]);

  // divide: one quotient bit per stage; saturate when num >= max_distance * 256
  always_comb begin
    logic [DW-1:0] d;
    logic          ge;
    for (int j = 0; j < CB; j++) begin
      d  = DW'(cfg_max_dist_r) << (CB - 1 - j);
      ge = (drem_r[j] >= d);
      drem_nxt[j+1] = ge ? drem_r[j] - d : drem_r[j];
      dq_nxt[j+1]   = {dq_r[j][CB-2:0], ge};
      dsat_nxt[j+1] = (j == 0) ? (drem_r[0] >= (DW'(cfg_max_dist_r) << CB)) : dsat_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r      <= dx_nxt;
      dy_r      <= dy_nxt;
      sq_x_r    <= SQ_BITS'(dx_r) * SQ_BITS'(dx_r);
      sq_y_r    <= SQ_BITS'(dy_r) * SQ_BITS'(dy_r);
      rad_r[0]  <= RAD_BITS'(SUM_BITS'(sq_x_r) + SUM_BITS'(sq_y_r));
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int k = 1; k <= RB; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
      drem_r[0] <= DW'(num_nxt);
      dq_r[0]   <= '0;
      dsat_r[0] <= 1'b0;
      for (int j = 1; j <= CB; j++) begin
        drem_r[j] <= drem_nxt[j];
        dq_r[j]   <= dq_nxt[j];
        dsat_r[j] <= dsat_nxt[j];
      end
    end
  end

  assign red       = dsat_r[CB] ? rgp_pkg::CHAN_FULL : dq_r[CB];
  assign color_nxt = {red, rgp_pkg::CHAN_ZERO, rgp_pkg::CHAN_FULL - red};

  assign push = en && vld_r[LAST];
  assign take = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_color_r <= skid_color_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_color_r <= color_nxt;
      end else begin
        out_color_r <= color_nxt;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

  `RGP_ASSERT_NOW(a_skid_needs_out, skid_valid_r, out_valid_r, "buffered item behind an empty output")
  `RGP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted item lost at entry")
  `RGP_ASSERT_NEXT(a_stall_to_skid, out_valid_r && !out_ready && vld_r[LAST] && !skid_valid_r, skid_valid_r, "item leaving pipeline not buffered")
  `RGP_ASSERT_NOW(a_color_shape, out_valid_r, (out_color_r[15:8] == rgp_pkg::CHAN_ZERO) && (out_color_r[7:0] == ~out_color_r[23:16]), "red and blue do not sum to full")

endmodule

### tb/sv/tb_radial_gradient_pixel_unit.sv
// Self-checking testbench for the radial gradient pixel unit: directed probes, then random phases.
`timescale 1ns / 100ps

module tb_radial_gradient_pixel_unit;

  localparam int COORD_BITS  = 11;
  localparam int LATENCY     = COORD_BITS + 13;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 150;
  localparam int N_PROBES    = 19;

  // Index past the last register; writes to it must change nothing.
  localparam logic [rgp_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [rgp_pkg::COLOR_BITS-1:0] color_t;
  typedef logic [rgp_pkg::CFG_INDEX_BITS-1:0] cfg_idx_t;
  typedef logic [rgp_pkg::CFG_DATA_BITS-1:0] cfg_data_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   known;
    color_t color;
  } probe_t;

  // Rows with known set carry a color read straight off the reset configuration.
  localparam probe_t PROBES [N_PROBES] = '{
    '{11'd400,  11'd300,  1'b1, 24'h0000FF},
    '{11'd401,  11'd300,  1'b1, 24'h0000FF},
    '{11'd0,    11'd0,    1'b1, 24'hFF0000},
    '{11'd800,  11'd600,  1'b1, 24'hFF0000},
    '{11'd2047, 11'd2047, 1'b1, 24'hFF0000},
    '{11'd400,  11'd550,  1'b1, 24'h7F0080},
    '{11'd650,  11'd300,  1'b1, 24'h7F0080},
    '{11'd0,    11'd2047, 1'b0, 24'h000000},
    '{11'd2047, 11'd0,    1'b0, 24'h000000},
    '{11'd2047, 11'd300,  1'b0, 24'h000000},
    '{11'd400,  11'd0,    1'b0, 24'h000000},
    '{11'd0,    11'd300,  1'b0, 24'h000000},
    '{11'd500,  11'd400,  1'b0, 24'h000000},
    '{11'd399,  11'd299,  1'b0, 24'h000000},
    '{11'd1234, 11'd567,  1'b0, 24'h000000},
    '{11'd1023, 11'd1024, 1'b0, 24'h000000},
    '{11'd10,   11'd20,   1'b0, 24'h000000},
    '{11'd400,  11'd800,  1'b0, 24'h000000},
    '{11'd777,  11'd333,  1'b0, 24'h000000}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  coord_t    in_pixel_x;
  coord_t    in_pixel_y;
  logic      out_valid;
  logic      out_ready;
  color_t    out_pixel_color;
  logic      cfg_wr_en;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_wdata;

  // Mirror of the block's registers.
  coord_t                        ctr_x;
  coord_t                        ctr_y;
  logic [rgp_pkg::MAXD_BITS-1:0] max_dist;

  color_t color_q [$];
  int     err_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_req_cnt;

  radial_gradient_pixel_unit #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_color(out_pixel_color),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic color_t gradient_color(coord_t px, coord_t py);
    coord_t      dx;
    coord_t      dy;
    logic [22:0] sq;
    logic [11:0] dist_root;
    logic [11:0] trial;
    logic [19:0] quot;
    logic [7:0]  red;
    dx = (px >= ctr_x) ? px - ctr_x : ctr_x - px;
    dy = (py >= ctr_y) ? py - ctr_y : ctr_y - py;
    sq = 23'(dx) * 23'(dx) + 23'(dy) * 23'(dy);
    // Build the floor root one bit at a time, most significant first.
    dist_root = '0;
    for (int b = 11; b >= 0; b--) begin
      trial = dist_root | (12'd1 << b);
      if (24'(trial) * 24'(trial) <= 24'(sq)) dist_root = trial;
    end
    if (max_dist == '0) begin
      red = rgp_pkg::CHAN_FULL;
    end else begin
      quot = (20'(dist_root) * 20'd255) / 20'(max_dist);
      red  = (quot > 20'd255) ? rgp_pkg::CHAN_FULL : quot[7:0];
    end
    return {red, rgp_pkg::CHAN_ZERO, rgp_pkg::CHAN_FULL - red};
  endfunction

  function automatic coord_t pick_coord(coord_t around);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return coord_t'(around + coord_t'($urandom_range(128)) - coord_t'(64));
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic cfg_write(cfg_idx_t idx, cfg_data_t data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rgp_pkg::CFG_CENTER_X: ctr_x = data[COORD_BITS-1:0];
      rgp_pkg::CFG_CENTER_Y: ctr_y = data[COORD_BITS-1:0];
      rgp_pkg::CFG_MAX_DIST: max_dist = data;
      default: ;
    endcase
  endtask

  task automatic program_gradient(cfg_data_t cx, cfg_data_t cy, cfg_data_t md);
    cfg_write(rgp_pkg::CFG_CENTER_X, cx);
    cfg_write(CFG_UNUSED, cfg_data_t'($urandom));
    cfg_write(rgp_pkg::CFG_CENTER_Y, cy);
    cfg_write(rgp_pkg::CFG_MAX_DIST, md);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one item; in_valid stays high after the accept so back-to-back items need no toggle.
  task automatic send_pixel(coord_t px, coord_t py, logic known, color_t color);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    do @(posedge clk); while (!in_ready);
    color_q.push_back(known ? color : gradient_color(px, py));
  endtask

  task automatic drain_colors();
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_pixel_x    <= '0;
    in_pixel_y    <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    recv_idle_pct <= 10;
    hold_req_cnt  <= 0;
    send_idle_pct = 10;
    ctr_x         = coord_t'(rgp_pkg::CENTER_X_RESET);
    ctr_y         = coord_t'(rgp_pkg::CENTER_Y_RESET);
    max_dist      = rgp_pkg::MAXD_BITS'(rgp_pkg::MAX_DIST_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i]) send_pixel(PROBES[i].x, PROBES[i].y, PROBES[i].known, PROBES[i].color);
    drain_colors();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // Bit 11 of the center data falls outside the coordinate width.
        0: program_gradient(12'h800, 12'h000, 12'hFFF);
        1: program_gradient(12'hFFF, 12'h7FF, 12'd1);
        2: program_gradient(12'd1024, 12'd1024, 12'd0);
        3: program_gradient(12'd400, 12'd300, 12'd500);
        default: program_gradient(cfg_data_t'($urandom), cfg_data_t'($urandom),
                                  ($urandom_range(3) == 0) ? cfg_data_t'($urandom)
                                                           : cfg_data_t'($urandom_range(1, 3000)));
      endcase
      // One stretch streams with no idling on either side.
      send_idle_pct = (ph == 3) ? 0 : 10;
      recv_idle_pct <= (ph == 3) ? 0 : 10;
      // Stall the output long enough to back the pipeline up into the input.
      if (ph == 5) hold_req_cnt <= hold_req_cnt + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(pick_coord(ctr_x), pick_coord(ctr_y), 1'b0, '0);
      end
      drain_colors();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0 && color_q.size() == 0) begin
      $display("tb_radial_gradient_pixel_unit: clean");
    end else begin
      $display("tb_radial_gradient_pixel_unit: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int holds_served;
    holds_served = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req_cnt != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk);
      end
    end
  end

  initial err_count = 0;

  always @(posedge clk) begin
    color_t want;
    if (rst_n && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        $display("%0t: unexpected color item %06h", $time, out_pixel_color);
        err_count++;
      end else begin
        want = color_q.pop_front();
        if (out_pixel_color !== want) begin
          $display("%0t: pixel_color mismatch: expected %06h, actual %06h",
                   $time, want, out_pixel_color);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #4000000;
    $display("tb_radial_gradient_pixel_unit: errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rgp_pkg.sv
rtl/radial_gradient_pixel_unit.sv
tb/sv/tb_radial_gradient_pixel_unit.sv
